>>> design/polynomial_rolling_string_hash_assert.svh
// Assertion macros for the rolling string hash block.
// Used by polynomial_rolling_string_hash.sv; expects i_clk and i_rst_n in scope.
`ifndef POLYNOMIAL_ROLLING_STRING_HASH_ASSERT_SVH
`define POLYNOMIAL_ROLLING_STRING_HASH_ASSERT_SVH

// Condition and consequence checked in the same cycle.
`define PRSH_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence checked in the cycle after the condition.
`define PRSH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/prsh_pkg.sv
// Shared types and constants of the rolling string hash block.
// No dependencies; used by the channel interfaces and the top level.
package prsh_pkg;

    localparam int LetterW = 7;
    localparam int HashW   = 30;
    localparam int TsizeW  = 31;
    localparam int DigitW  = 5;
    localparam int CntW    = 5;

    localparam logic [TsizeW-1:0]  HashMod    = 31'd1000000009;
    localparam logic [LetterW-1:0] LetterA    = 7'd97;
    localparam logic [LetterW-1:0] LetterZ    = 7'd122;
    localparam logic [LetterW-1:0] LetterBias = 7'd96;
    localparam logic [TsizeW-1:0]  TsizeReset = 31'd97;

    // One step per bit of the letter value, one step per bit of the raw hash.
    localparam logic [CntW-1:0] MacLast = CntW'(DigitW - 1);
    localparam logic [CntW-1:0] DivLast = CntW'(HashW - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC,
        S_DIV,
        S_OUT
    } t_state;

    // Sum of two residues, reduced once; both operands are below the modulus.
    function automatic logic [HashW-1:0] mod_add(input logic [HashW-1:0] a,
                                                 input logic [HashW-1:0] b);
        logic [TsizeW-1:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= HashMod) begin
            s = s - HashMod;
        end
        return s[HashW-1:0];
    endfunction

endpackage

>>> design/prsh_if.sv
// Valid/ready channel interfaces for letters in and hash results out.
// Depends on prsh_pkg for the field widths.
interface prsh_in_if;
    logic                          valid;
    logic                          ready;
    logic [prsh_pkg::LetterW-1:0]  letter;
    logic                          last_letter;

    modport source (output valid, letter, last_letter, input ready);
    modport sink   (input valid, letter, last_letter, output ready);
endinterface

interface prsh_out_if;
    logic                          valid;
    logic                          ready;
    logic [prsh_pkg::HashW-1:0]    raw_hash;
    logic [prsh_pkg::TsizeW-1:0]   bucket_index;

    modport source (output valid, raw_hash, bucket_index, input ready);
    modport sink   (input valid, raw_hash, bucket_index, output ready);
endinterface

>>> design/polynomial_rolling_string_hash.sv
// Polynomial rolling string hash, base 31, modulo 1000000009. A letter is taken in S_IDLE and
// then passes a bit-serial multiply in S_MAC that walks the letter value one bit per cycle
// while doubling the power, so both the hash and the next power come from three narrow
// modular adders. A last letter adds a restoring division in S_DIV, one bit of the raw hash
// per cycle, against table_size, and S_OUT then loads the result register; a table size
// of 0 returns the raw hash as bucket index. Letters outside 'a' to 'z' leave the hash alone
// and skip the multiply. The result register lets the next string start while a result
// waits. Depends on prsh_pkg, prsh_if.sv and the assertion header.
`include "polynomial_rolling_string_hash_assert.svh"

module polynomial_rolling_string_hash (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    prsh_in_if.sink                      i_in,
    prsh_out_if.source                   o_out,
    input  logic                         i_cfg_we,
    input  logic [prsh_pkg::TsizeW-1:0]  i_cfg_data
);
    import prsh_pkg::*;

    t_state              r_state, n_state;
    logic [HashW-1:0]    r_hash, n_hash;
    logic [HashW-1:0]    r_pow, n_pow;
    logic [HashW-1:0]    r_pacc, n_pacc;
    logic [DigitW-1:0]   r_dig, n_dig;
    logic [CntW-1:0]     r_cnt, n_cnt;
    logic                r_last, n_last;
    logic [HashW-1:0]    r_quo, n_quo;
    logic [TsizeW-1:0]   r_rem, n_rem;
    logic [TsizeW-1:0]   r_tsize;
    logic                r_ov, n_ov;
    logic [HashW-1:0]    r_raw;
    logic [TsizeW-1:0]   r_bkt;

    logic                in_ready, accept, letter_ok;
    logic                mac_step, mac_last, div_step, div_start, ld_out, slot_free;
    logic [DigitW-1:0]   dig_full;
    logic [TsizeW:0]     trial;

    assign accept    = i_in.valid && in_ready;
    assign letter_ok = i_in.letter inside {[LetterA:LetterZ]};
    assign dig_full  = DigitW'(i_in.letter - LetterBias);
    assign slot_free = !r_ov || o_out.ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (letter_ok) begin
                        n_state = S_MAC;
                    end else if (i_in.last_letter) begin
                        n_state = S_DIV;
                    end
                end
            end
            S_MAC: begin
                if (r_cnt == MacLast) begin
                    n_state = r_last ? S_DIV : S_IDLE;
                end
            end
            S_DIV: begin
                if (r_cnt == DivLast) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control decode.
    always_comb begin
        in_ready = 1'b0;
        mac_step = 1'b0;
        div_step = 1'b0;
        ld_out   = 1'b0;
        case (r_state)
            S_IDLE:  in_ready = 1'b1;
            S_MAC:   mac_step = 1'b1;
            S_DIV:   div_step = 1'b1;
            S_OUT:   ld_out   = slot_free;
            default: in_ready = 1'b0;
        endcase
    end

    assign mac_last  = mac_step && (r_cnt == MacLast);
    assign div_start = (accept && !letter_ok && i_in.last_letter) || (mac_last && r_last);

    // Datapath next values.
    always_comb begin
        n_hash = r_hash;
        n_pow  = r_pow;
        n_pacc = r_pacc;
        n_dig  = r_dig;
        n_cnt  = r_cnt;
        n_last = r_last;
        n_quo  = r_quo;
        n_rem  = r_rem;
        trial  = '0;

        if (accept) begin
            n_dig  = dig_full;
            n_last = i_in.last_letter;
            n_pacc = '0;
            n_cnt  = '0;
        end

        // r_pow doubles each step but the last, where it takes r_pacc, the sum of the doublings, 31 * power.
        if (mac_step) begin
            if (r_dig[0]) begin
                n_hash = mod_add(r_hash, r_pow);
            end
            n_pacc = mod_add(r_pacc, r_pow);
            n_pow  = mac_last ? n_pacc : mod_add(r_pow, r_pow);
            n_dig  = r_dig >> 1;
            n_cnt  = r_cnt + 1'b1;
        end

        if (div_start) begin
            n_quo = n_hash;
            n_rem = '0;
            n_cnt = '0;
        end

        // With a table size of zero the subtraction removes nothing and the raw hash
        // shifts through into the remainder unchanged.
        if (div_step) begin
            trial = {r_rem, r_quo[HashW-1]};
            if (trial >= {1'b0, r_tsize}) begin
                trial = trial - {1'b0, r_tsize};
            end
            n_rem = trial[TsizeW-1:0];
            n_quo = r_quo << 1;
            n_cnt = r_cnt + 1'b1;
        end

        if (ld_out) begin
            n_hash = '0;
            n_pow  = HashW'(1);
        end

        if (ld_out) begin
            n_ov = 1'b1;
        end else if (o_out.ready) begin
            n_ov = 1'b0;
        end else begin
            n_ov = r_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_hash  <= '0;
            r_pow   <= HashW'(1);
            r_cnt   <= '0;
            r_last  <= 1'b0;
            r_ov    <= 1'b0;
            r_tsize <= TsizeReset;
        end else begin
            r_state <= n_state;
            r_hash  <= n_hash;
            r_pow   <= n_pow;
            r_cnt   <= n_cnt;
            r_last  <= n_last;
            r_ov    <= n_ov;
            if (i_cfg_we) begin
                r_tsize <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pacc <= n_pacc;
        r_dig  <= n_dig;
        r_quo  <= n_quo;
        r_rem  <= n_rem;
        if (ld_out) begin
            r_raw <= r_hash;
            r_bkt <= r_rem;
        end
    end

    assign i_in.ready         = in_ready;
    assign o_out.valid        = r_ov;
    assign o_out.raw_hash     = r_raw;
    assign o_out.bucket_index = r_bkt;

    `PRSH_ASSERT_SAME(a_residues, 1'b1, (r_hash < HashMod[HashW-1:0]) && (r_pow < HashMod[HashW-1:0]), "hash or power left the residue range")
    `PRSH_ASSERT_NEXT(a_restart, ld_out, (r_hash == '0) && (r_pow == HashW'(1)) && r_ov, "string did not restart after its result")
    `PRSH_ASSERT_NEXT(a_div_end, (r_state == S_DIV) && (r_cnt == DivLast), r_state == S_OUT, "division did not end after the last hash bit")

endmodule
